FILE: src/irtsfd_pkg.sv
package irtsfd_pkg;

  // frame geometry
  localparam int DATA_BITS = 20;
  localparam int CNT_W     = $clog2(DATA_BITS + 1);
  localparam int VALUE_W   = 20;
  localparam int DUR_W     = 16;
  localparam int TIME_W    = DUR_W + 2;  // signed leftover time
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int OUT_W     = 24;         // accepted + status + value, byte padded

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TICK       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_MIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_MIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FOOTER_MIN = 3'd4;

  // decoder phase within a capture
  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_DATA    = 2'd1,
    PH_FOOTER  = 2'd2,
    PH_DISCARD = 2'd3
  } phase_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_HDR_SHORT  = 2'd1,
    ST_FEW_BITS   = 2'd2,
    ST_FOOT_SHORT = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    SQ_IDLE  = 2'd0,
    SQ_SLICE = 2'd1,
    SQ_EMIT  = 2'd2
  } seq_t;

endpackage

FILE: src/ir_tick_sliced_frame_decoder.sv
// Infrared tick-sliced frame decoder.
// Input channel in_*: one mark or space duration per transfer, in_tdata[15:0]
// is the duration in us, in_tlast marks the final duration of a capture. The
// first duration of a capture is the header mark; levels alternate after it.
// Output channel out_*: at most one result per capture, issued at the
// duration where the outcome is decided; later durations of that capture
// up to in_tlast are dropped without a result.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 tick,
// 1 tick minimum, 2 header, 3 header minimum, 4 footer minimum); the user
// writes only while idle, which the block itself does not enforce.
// Timing: one shared subtract/compare unit slices one bit per cycle; a duration
// holds in_tready low while its bits are sliced (0 to 20) and its result is
// loaded; a short header or footer only for the load, a dropped one not at all.
// A stalled receiver holds the result in the output register; the next
// duration is still taken and worked on, and only a second result waits
// for the register to free up.
// Reset (rst_n low, synchronous) restores default registers, clears the
// output and restarts at header detection.
module ir_tick_sliced_frame_decoder
  import irtsfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [DUR_W-1:0]     in_tdata,   // [15:0] duration_us
  input  logic                 in_tlast,   // last_in_capture
  // result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_W-1:0]     out_tdata,  // [0] accepted, [2:1] status,
                                           // [22:3] frame_value, [23] zero
  // configuration writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // configuration registers
  logic [CFG_W-1:0] tick_r, tick_min_r, header_r, header_min_r, footer_min_r;

  // sequencer and decode state
  seq_t                      seq_r, seq_nxt;
  phase_t                    phase_r, phase_nxt;
  logic signed [TIME_W-1:0]  left_r, left_nxt;
  logic                      mark_r, mark_nxt;
  logic [CNT_W-1:0]          bcnt_r, bcnt_nxt;
  logic [VALUE_W-1:0]        shift_r, shift_nxt;
  logic                      last_r, last_nxt;
  status_t                   pend_r, pend_nxt;

  // output register
  logic                      ovalid_r, ovalid_nxt;
  logic                      oacc_r, oacc_nxt;
  status_t                   ostat_r, ostat_nxt;
  logic [VALUE_W-1:0]        oval_r, oval_nxt;

  // shared slice unit signals
  logic [TIME_W-1:0]         tick_ext;
  logic                      left_pos;
  logic                      left_ge_tmin;
  logic                      left_ge_fmin;
  logic                      bits_open;
  logic                      slice_go;
  logic signed [TIME_W-1:0]  left_dec;
  logic                      in_xfer;
  logic                      out_free;

  assign in_tready  = (seq_r == SQ_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_free   = !ovalid_r || out_tready;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {1'b0, oval_r, ostat_r, oacc_r};

  // one subtract and two compares on the leftover time
  assign tick_ext     = (tick_r == '0) ? TIME_W'(1) : {2'b00, tick_r};
  assign left_pos     = !left_r[TIME_W-1] && (left_r != '0);
  assign left_ge_tmin = left_r[TIME_W-2:0] >= {1'b0, tick_min_r};
  assign left_ge_fmin = left_r[TIME_W-2:0] >= {1'b0, footer_min_r};
  assign bits_open    = bcnt_r < CNT_W'(DATA_BITS);
  assign slice_go     = bits_open && left_pos && left_ge_tmin;
  assign left_dec     = left_r - $signed(tick_ext);

  // configuration write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r       <= CFG_W'(150);
      tick_min_r   <= CFG_W'(120);
      header_r     <= CFG_W'(750);
      header_min_r <= CFG_W'(600);
      footer_min_r <= CFG_W'(600);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TICK:       tick_r       <= cfg_data;
        REG_TICK_MIN:   tick_min_r   <= cfg_data;
        REG_HEADER:     header_r     <= cfg_data;
        REG_HEADER_MIN: header_min_r <= cfg_data;
        REG_FOOTER_MIN: footer_min_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // next sequencer state
  always_comb begin
    seq_nxt = seq_r;
    case (seq_r)
      SQ_IDLE: begin
        if (in_xfer) begin
          case (phase_r)
            PH_HEADER: seq_nxt = (in_tdata < header_min_r) ? SQ_EMIT : SQ_SLICE;
            PH_DATA:   seq_nxt = SQ_SLICE;
            PH_FOOTER: seq_nxt = SQ_EMIT;
            default:   seq_nxt = SQ_IDLE;
          endcase
        end
      end
      SQ_SLICE: begin
        if (!slice_go) begin
          if (bits_open) seq_nxt = last_r ? SQ_EMIT : SQ_IDLE;
          else if (left_pos) seq_nxt = SQ_EMIT;
          else seq_nxt = last_r ? SQ_EMIT : SQ_IDLE;
        end
      end
      SQ_EMIT: begin
        if (out_free) seq_nxt = SQ_IDLE;
      end
      default: seq_nxt = SQ_IDLE;
    endcase
  end

  // datapath and output register updates
  always_comb begin
    phase_nxt  = phase_r;
    left_nxt   = left_r;
    mark_nxt   = mark_r;
    bcnt_nxt   = bcnt_r;
    shift_nxt  = shift_r;
    last_nxt   = last_r;
    pend_nxt   = pend_r;
    ovalid_nxt = ovalid_r && !out_tready;
    oacc_nxt   = oacc_r;
    ostat_nxt  = ostat_r;
    oval_nxt   = oval_r;
    case (seq_r)
      // take a duration: set up the slice loop, judge a footer or drop a discarded one
      SQ_IDLE: begin
        if (in_xfer) begin
          last_nxt = in_tlast;
          case (phase_r)
            PH_HEADER: begin
              mark_nxt  = 1'b1;
              bcnt_nxt  = '0;
              shift_nxt = '0;
              pend_nxt  = ST_HDR_SHORT;
              left_nxt  = $signed({2'b00, in_tdata}) - $signed({2'b00, header_r});
            end
            PH_DATA: begin
              mark_nxt = !mark_r;
              left_nxt = $signed({2'b00, in_tdata});
            end
            PH_FOOTER: begin
              pend_nxt = (in_tdata >= footer_min_r) ? ST_OK : ST_FOOT_SHORT;
            end
            default: begin
              if (in_tlast) phase_nxt = PH_HEADER;
            end
          endcase
        end
      end
      // one tick slice per cycle, then the pending status and next phase once slicing stops
      SQ_SLICE: begin
        if (slice_go) begin
          shift_nxt = {shift_r[VALUE_W-2:0], mark_r};
          bcnt_nxt  = bcnt_r + CNT_W'(1);
          left_nxt  = left_dec;
        end else if (bits_open) begin
          pend_nxt = ST_FEW_BITS;
          if (!last_r) phase_nxt = PH_DATA;
        end else if (left_pos) begin
          pend_nxt = left_ge_fmin ? ST_OK : ST_FOOT_SHORT;
        end else begin
          pend_nxt = ST_OK;
          if (!last_r) phase_nxt = PH_FOOTER;
        end
      end
      // load the result once the output register is free
      SQ_EMIT: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          oacc_nxt   = (pend_r == ST_OK);
          ostat_nxt  = pend_r;
          oval_nxt   = (pend_r == ST_OK) ? shift_r : '0;
          phase_nxt  = last_r ? PH_HEADER : PH_DISCARD;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r    <= SQ_IDLE;
      phase_r  <= PH_HEADER;
      ovalid_r <= 1'b0;
      mark_r   <= 1'b1;
      bcnt_r   <= '0;
      left_r   <= '0;
      shift_r  <= '0;
    end else begin
      seq_r    <= seq_nxt;
      phase_r  <= phase_nxt;
      ovalid_r <= ovalid_nxt;
      mark_r   <= mark_nxt;
      bcnt_r   <= bcnt_nxt;
      left_r   <= left_nxt;
      shift_r  <= shift_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    last_r  <= last_nxt;
    pend_r  <= pend_nxt;
    oacc_r  <= oacc_nxt;
    ostat_r <= ostat_nxt;
    oval_r  <= oval_nxt;
  end

endmodule

FILE: bench/ir_tick_sliced_frame_decoder_tb.sv
module ir_tick_sliced_frame_decoder_tb;
  import irtsfd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 40;    // covers the longest ordinary duration
  localparam int RX_LONG_HOLD  = 300;   // receiver hold-off for the backpressure test
  localparam int RANDOM_ITEMS  = 1250;

  // one decoded capture as it leaves the block
  typedef struct {
    logic                 accepted;
    status_t              status;
    logic [VALUE_W-1:0]   value;
  } frame_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [DUR_W-1:0]     in_tdata = '0;   // [15:0] duration_us
  logic                 in_tlast = 1'b0; // last_in_capture
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_W-1:0]     out_tdata;       // [0] accepted, [2:1] status,
                                         // [22:3] frame_value, [23] zero
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // decoder copy: registers and capture state
  logic [CFG_W-1:0]     dec_tick = 16'd150;
  logic [CFG_W-1:0]     dec_tick_min = 16'd120;
  logic [CFG_W-1:0]     dec_hdr = 16'd750;
  logic [CFG_W-1:0]     dec_hdr_min = 16'd600;
  logic [CFG_W-1:0]     dec_foot_min = 16'd600;
  phase_t               dec_phase = PH_HEADER;
  int                   dec_left = 0;
  bit                   dec_mark = 1'b1;
  int                   dec_bits = 0;
  logic [VALUE_W-1:0]   dec_shift = '0;

  frame_result_t        expected_frames[$];
  int                   error_count = 0;
  int                   items_sent = 0;

  // sender burst bookkeeping
  int                   burst_left = 0;
  int                   gap_max = 6;

  // receiver stall pattern
  int                   rx_hold_seq = 0;
  int                   rx_hold_seen = 0;
  int                   rx_hold_left = 0;
  int                   rx_mode = 0;
  int                   rx_stretch = 0;
  int                   rx_cycle = 0;

  ir_tick_sliced_frame_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ends the capture with a verdict and picks the next phase
  function automatic frame_result_t close_frame(input status_t st, input bit last);
    frame_result_t r;
    r.accepted = (st == ST_OK);
    r.status   = st;
    r.value    = (st == ST_OK) ? dec_shift : '0;
    dec_phase  = last ? PH_HEADER : PH_DISCARD;
    return r;
  endfunction

  // advances the decoder copy by one duration; returns 1 when a frame result is due
  function automatic bit decode_duration(input logic [DUR_W-1:0] dur, input bit last,
                                         output frame_result_t res);
    int tick;
    tick = (dec_tick == 0) ? 1 : int'(dec_tick);
    res = '{1'b0, ST_OK, '0};
    case (dec_phase)
      PH_HEADER: begin
        dec_mark  = 1'b1;
        dec_bits  = 0;
        dec_shift = '0;
        if (dur < dec_hdr_min) begin
          res = close_frame(ST_HDR_SHORT, last);
          return 1'b1;
        end
        dec_left = int'(dur) - int'(dec_hdr);
      end
      PH_DATA: begin
        dec_mark = !dec_mark;
        dec_left = int'(dur);
      end
      PH_FOOTER: begin
        res = close_frame((dur >= dec_foot_min) ? ST_OK : ST_FOOT_SHORT, last);
        return 1'b1;
      end
      default: begin
        if (last)
          dec_phase = PH_HEADER;
        return 1'b0;
      end
    endcase
    // slice the duration into ticks
    while (dec_bits < DATA_BITS && dec_left > 0) begin
      if (dec_left >= int'(dec_tick_min)) begin
        dec_shift = {dec_shift[VALUE_W-2:0], dec_mark};
        dec_bits++;
      end
      dec_left -= tick;
    end
    if (dec_bits < DATA_BITS) begin
      if (last) begin
        res = close_frame(ST_FEW_BITS, 1'b1);
        return 1'b1;
      end
      dec_phase = PH_DATA;
      return 1'b0;
    end
    if (dec_left > 0) begin
      res = close_frame((dec_left >= int'(dec_foot_min)) ? ST_OK : ST_FOOT_SHORT, last);
      return 1'b1;
    end
    if (last) begin
      res = close_frame(ST_OK, 1'b1);
      return 1'b1;
    end
    dec_phase = PH_FOOTER;
    return 1'b0;
  endfunction

  function automatic logic [DUR_W-1:0] fit_duration(input int d);
    if (d < 0)
      return '0;
    if (d > 65535)
      return 16'hFFFF;
    return d[DUR_W-1:0];
  endfunction

  function automatic int tick_jitter(input int tick);
    return (tick > 1) ? int'($urandom_range(0, tick - 1)) : 0;
  endfunction

  // one input transfer, with bursty gaps in front
  task automatic send_duration(input logic [DUR_W-1:0] dur, input bit last);
    frame_result_t r;
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 7) == 0)
        gap_max = ($urandom_range(0, 2) == 0) ? 0 : 6;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= dur;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    items_sent++;
    if (decode_duration(dur, last, r))
      expected_frames.push_back(r);
  endtask

  // sender pauses until every expected frame has come out
  task automatic drain_results();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_frames.size() != 0) @(posedge clk);
  endtask

  // block idle: no frames pending and no duration being sliced
  task automatic settle_block();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic write_config(input logic [CFG_W-1:0] tick, input logic [CFG_W-1:0] tick_min,
                              input logic [CFG_W-1:0] hdr, input logic [CFG_W-1:0] hdr_min,
                              input logic [CFG_W-1:0] foot_min);
    logic [CFG_IDX_W-1:0] idx_list [5];
    logic [CFG_W-1:0]     val_list [5];
    idx_list = '{REG_TICK, REG_TICK_MIN, REG_HEADER, REG_HEADER_MIN, REG_FOOTER_MIN};
    val_list = '{tick, tick_min, hdr, hdr_min, foot_min};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx_list[i];
      cfg_data  <= val_list[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    dec_tick     = tick;
    dec_tick_min = tick_min;
    dec_hdr      = hdr;
    dec_hdr_min  = hdr_min;
    dec_foot_min = foot_min;
  endtask

  task automatic write_random_config();
    int tick;
    int hdr;
    settle_block();
    tick = $urandom_range(20, 400);
    hdr  = $urandom_range(0, 2000);
    write_config(CFG_W'(tick),
                 CFG_W'(($urandom_range(0, 4) == 0) ? $urandom_range(tick, tick + 100)
                                                    : $urandom_range(1, tick)),
                 CFG_W'(hdr), CFG_W'($urandom_range(0, hdr + tick)),
                 CFG_W'($urandom_range(0, 1500)));
  endtask

  // one capture shaped after the current registers, mostly well formed
  task automatic send_capture();
    int tick;
    int dur;
    int n_data;
    int n_noise;
    bit last;
    tick = (dec_tick == 0) ? 1 : int'(dec_tick);
    // noise: arbitrary durations
    if ($urandom_range(0, 9) == 0) begin
      n_noise = $urandom_range(1, 8);
      for (int i = 0; i < n_noise; i++)
        send_duration(DUR_W'($urandom_range(0, 65535)), i == n_noise - 1);
      return;
    end
    // header mark, sometimes too short
    if (dec_hdr_min > 0 && $urandom_range(0, 7) == 0)
      dur = $urandom_range(0, dec_hdr_min - 1);
    else
      dur = int'(dec_hdr) + int'($urandom_range(0, 4)) * tick + tick_jitter(tick);
    send_duration(fit_duration(dur), $urandom_range(0, 49) == 0);
    // data durations until the bit count is reached or the capture is cut short
    n_data = 0;
    while (dec_phase == PH_DATA) begin
      n_data++;
      last = (n_data >= 40) || ($urandom_range(0, 29) == 0);
      dur = int'($urandom_range(0, 5)) * tick + tick_jitter(tick);
      send_duration(fit_duration(dur), last);
    end
    // separate footer duration around its threshold
    if (dec_phase == PH_FOOTER) begin
      if ($urandom_range(0, 1))
        dur = int'(dec_foot_min) + int'($urandom_range(0, 200));
      else
        dur = int'(dec_foot_min) - int'($urandom_range(1, 200));
      send_duration(fit_duration(dur), $urandom_range(0, 3) != 0);
    end
    // rest of a capture decided early is dropped by the block
    while (dec_phase == PH_DISCARD)
      send_duration(DUR_W'($urandom_range(0, 65535)), $urandom_range(0, 2) == 0);
  endtask

  // directed frames under the reset registers
  task automatic test_directed_cases();
    // lone short header
    send_duration(16'd599, 1'b1);
    // short header decided early, rest of capture dropped
    send_duration(16'd100, 1'b0);
    send_duration(16'd0, 1'b0);
    send_duration(16'hFFFF, 1'b1);
    // header at its minimum, capture ends with no bits
    send_duration(16'd600, 1'b1);
    // longest header fills every bit and leaves a long footer
    send_duration(16'hFFFF, 1'b0);
    send_duration(16'd300, 1'b1);
    // exact bit count, zero-length data duration, separate footer
    send_duration(16'd1200, 1'b0);
    send_duration(16'd0, 1'b0);
    send_duration(16'd2550, 1'b0);
    send_duration(16'd600, 1'b1);
    // capture ends right after the last bit
    send_duration(16'd1200, 1'b0);
    send_duration(16'd0, 1'b0);
    send_duration(16'd2550, 1'b1);
    // leftover just below the footer minimum
    send_duration(16'd1200, 1'b0);
    send_duration(16'd3149, 1'b0);
    send_duration(16'd10, 1'b1);
    // slices around the tick minimum, capture ends mid-frame
    send_duration(16'd1200, 1'b0);
    send_duration(16'd130, 1'b0);
    send_duration(16'd119, 1'b1);
    // separate footer too short
    send_duration(16'd1200, 1'b0);
    send_duration(16'd2550, 1'b0);
    send_duration(16'd599, 1'b1);
    drain_results();
  endtask

  // receiver holds off while every transfer produces a frame
  task automatic test_output_backpressure();
    rx_hold_seq++;
    repeat (2) @(posedge clk);
    repeat (12)
      send_duration(DUR_W'($urandom_range(0, dec_hdr_min - 1)), 1'b1);
    drain_results();
  endtask

  task automatic test_random_captures(input int n_items);
    int stop_at;
    int next_pause;
    stop_at = items_sent + n_items;
    next_pause = items_sent + 150;
    while (items_sent < stop_at) begin
      send_capture();
      if (items_sent >= next_pause) begin
        drain_results();
        next_pause = items_sent + 150;
      end
    end
  endtask

  task automatic test_config_extremes();
    // smallest registers
    settle_block();
    write_config(16'd1, 16'd1, 16'd0, 16'd0, 16'd0);
    repeat (4) send_capture();
    // zero tick saturates to one
    settle_block();
    write_config(16'd0, 16'd1, 16'd10, 16'd5, 16'd3);
    repeat (4) send_capture();
    // largest registers
    settle_block();
    write_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (3) send_capture();
    // tiny tick with the largest tick minimum: slicing stops once the leftover falls below the minimum
    settle_block();
    write_config(16'd1, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
    send_duration(16'hFFFF, 1'b1);
    send_duration(16'hFFFE, 1'b1);
  endtask

  // receiver stall pattern with an on-demand long hold-off
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_hold_seq != rx_hold_seen) begin
      rx_hold_seen <= rx_hold_seq;
      rx_hold_left <= RX_LONG_HOLD;
      out_tready   <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_tready   <= 1'b0;
    end else begin
      if (rx_stretch == 0) begin
        rx_mode    <= $urandom_range(0, 3);
        rx_stretch <= $urandom_range(32, 256);
      end else begin
        rx_stretch <= rx_stretch - 1;
      end
      case (rx_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= ($urandom_range(0, 3) != 0);
        2:       out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= (rx_cycle % 5 != 0);
      endcase
    end
  end

  // compare each result transfer with the oldest expected frame
  always @(posedge clk) begin : result_check
    frame_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_frames.size() == 0) begin
        $error("unexpected result transfer, data %h", out_tdata);
        error_count++;
      end else begin
        want = expected_frames.pop_front();
        if (out_tdata[0] !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, out_tdata[0]);
          error_count++;
        end
        if (out_tdata[2:1] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tdata[2:1]);
          error_count++;
        end
        if (out_tdata[22:3] !== want.value) begin
          $error("frame_value: expected %h, got %h", want.value, out_tdata[22:3]);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_output_backpressure();
    test_random_captures(400);
    write_random_config();
    test_random_captures(400);
    test_config_extremes();
    write_random_config();
    test_random_captures(RANDOM_ITEMS - items_sent);
    settle_block();
    if (error_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // hard limit on the run
  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
